### rtl/sha256_stream_hasher_core_defines.svh
// Assertion macros shared by the SHA-256 stream hasher checkers.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sha256_pkg.sv
// Shared types for the SHA-256 stream hasher: controller states and the
// command/status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_COMPRESS,
        ST_ADD,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      push;
        byte_sel_t byte_sel;
        logic      count_byte;
        logic      round_en;
        logic [5:0] round_idx;
        logic      add_en;
        logic      finish;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_56;
        logic fill_63;
        logic fill_64;
        logic out_busy;
    } dp_status_t;

endpackage

### rtl/sha256_ctrl.sv
// Controller FSM for the SHA-256 stream hasher: sequences byte intake,
// padding, the 64 compression rounds and digest hand-off. Uses sha256_pkg.
`timescale 1ns / 1ps

module sha256_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tuser,
    input  logic                   s_tlast,
    output logic                   s_tready,
    input  sha256_pkg::dp_status_t status,
    output sha256_pkg::dp_cmd_t    cmd
);

    sha256_pkg::ctrl_state_t state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic       end_reg, end_next;
    logic       pad_reg, pad_next;
    logic       final_reg, final_next;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256_pkg::ST_IDLE;
            round_reg <= '0;
            end_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            end_reg   <= end_next;
            pad_reg   <= pad_next;
            final_reg <= final_next;
        end
    end

    // next state and flags
    always_comb
    begin
        state_next = state_reg;
        round_next = '0;
        end_next   = end_reg;
        pad_next   = pad_reg;
        final_next = final_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    end_next = s_tlast;
                    if (s_tuser && status.fill_63)
                        state_next = sha256_pkg::ST_COMPRESS;
                    else if (s_tlast)
                        state_next = sha256_pkg::ST_PAD_MARK;
                end
            end
            sha256_pkg::ST_PAD_MARK:
            begin
                pad_next   = 1'b1;
                state_next = sha256_pkg::ST_PAD_ZERO;
            end
            sha256_pkg::ST_PAD_ZERO:
            begin
                if (status.fill_56)
                    state_next = sha256_pkg::ST_PAD_LEN;
                else if (status.fill_64)
                    state_next = sha256_pkg::ST_COMPRESS;
            end
            sha256_pkg::ST_PAD_LEN:
            begin
                if (status.fill_63)
                begin
                    final_next = 1'b1;
                    state_next = sha256_pkg::ST_COMPRESS;
                end
            end
            sha256_pkg::ST_COMPRESS:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = sha256_pkg::ST_ADD;
            end
            sha256_pkg::ST_ADD:
            begin
                if (final_reg)
                    state_next = sha256_pkg::ST_FINISH;
                else if (pad_reg)
                    state_next = sha256_pkg::ST_PAD_ZERO;
                else if (end_reg)
                    state_next = sha256_pkg::ST_PAD_MARK;
                else
                    state_next = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    end_next   = 1'b0;
                    pad_next   = 1'b0;
                    final_next = 1'b0;
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.byte_sel   = sha256_pkg::SEL_DATA;
        cmd.round_idx  = round_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.push       = accept && s_tuser;
                cmd.count_byte = accept && s_tuser;
            end
            sha256_pkg::ST_PAD_MARK:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = sha256_pkg::SEL_MARK;
            end
            sha256_pkg::ST_PAD_ZERO:
            begin
                cmd.push     = !status.fill_56 && !status.fill_64;
                cmd.byte_sel = sha256_pkg::SEL_ZERO;
            end
            sha256_pkg::ST_PAD_LEN:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = sha256_pkg::SEL_LEN;
            end
            sha256_pkg::ST_COMPRESS:
            begin
                cmd.round_en = 1'b1;
            end
            sha256_pkg::ST_ADD:
            begin
                cmd.add_en = 1'b1;
            end
            sha256_pkg::ST_FINISH:
            begin
                cmd.finish = !status.out_busy;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/sha256_datapath.sv
// Datapath for the SHA-256 stream hasher: byte shift buffer that doubles as
// the message schedule window, round registers, hash words, digest output.
// Uses sha256_pkg for the command and status bundles.
`timescale 1ns / 1ps

module sha256_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             s_tdata,
    input  sha256_pkg::dp_cmd_t    cmd,
    output sha256_pkg::dp_status_t status,
    output logic [31:0]            m_tdata,
    output logic [2:0]             m_tuser,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready
);

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [6:0] FILL_LEN = 7'd56;
    localparam logic [6:0] FILL_TOP = 7'd63;
    localparam logic [6:0] FILL_FULL = 7'd64;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [511:0] buf_reg;
    logic [6:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  out_reg [8];
    logic [2:0]   out_idx_reg;
    logic         out_valid_reg;

    logic [7:0]   push_byte;
    logic [31:0]  src [8];
    logic [31:0]  w0, w1, w9, w14, w_new, sg0, sg1;
    logic [31:0]  bs0, bs1, ch, mj, t1;
    logic         out_take;

    assign status.fill_56  = (fill_reg == FILL_LEN);
    assign status.fill_63  = (fill_reg == FILL_TOP);
    assign status.fill_64  = (fill_reg == FILL_FULL);
    assign status.out_busy = out_valid_reg;

    // length bytes go out most significant first, one per fill slot 56..63
    always_comb
    begin
        case (cmd.byte_sel)
            sha256_pkg::SEL_DATA: push_byte = s_tdata;
            sha256_pkg::SEL_MARK: push_byte = PAD_MARK;
            sha256_pkg::SEL_ZERO: push_byte = 8'h00;
            sha256_pkg::SEL_LEN:  push_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
            default:              push_byte = 8'h00;
        endcase
    end

    // schedule window: oldest word at the top of the buffer
    assign w0    = buf_reg[511:480];
    assign w1    = buf_reg[479:448];
    assign w9    = buf_reg[223:192];
    assign w14   = buf_reg[63:32];
    assign sg0   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign sg1   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign w_new = w0 + sg0 + w9 + sg1;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            src[i] = (cmd.round_idx == 6'd0) ? h_reg[i] : v_reg[i];
    end

    assign bs1 = rotr(src[4], 6) ^ rotr(src[4], 11) ^ rotr(src[4], 25);
    assign ch  = (src[4] & src[5]) ^ (~src[4] & src[6]);
    assign t1  = src[7] + bs1 + ch + ROUND_K[cmd.round_idx] + w0;
    assign bs0 = rotr(src[0], 2) ^ rotr(src[0], 13) ^ rotr(src[0], 22);
    assign mj  = (src[0] & src[1]) ^ (src[0] & src[2]) ^ (src[1] & src[2]);

    assign out_take = out_valid_reg && m_tready;

    // payload: block buffer, working variables, digest words
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            buf_reg <= {buf_reg[503:0], push_byte};
        else if (cmd.round_en)
            buf_reg <= {buf_reg[479:0], w_new};

        if (cmd.round_en)
        begin
            v_reg[7] <= src[6];
            v_reg[6] <= src[5];
            v_reg[5] <= src[4];
            v_reg[4] <= src[3] + t1;
            v_reg[3] <= src[2];
            v_reg[2] <= src[1];
            v_reg[1] <= src[0];
            v_reg[0] <= t1 + bs0 + mj;
        end

        if (cmd.finish)
            out_reg <= h_reg;
        else if (out_take)
        begin
            for (int i = 0; i < 7; i++)
                out_reg[i] <= out_reg[i + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            bits_reg      <= '0;
            h_reg         <= INIT_H;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                fill_reg <= '0;
                bits_reg <= '0;
                h_reg    <= INIT_H;
            end
            else
            begin
                if (cmd.push)
                    fill_reg <= fill_reg + 7'd1;
                else if (cmd.add_en)
                    fill_reg <= '0;
                if (cmd.count_byte)
                    bits_reg <= bits_reg + 64'd8;
                if (cmd.add_en)
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= '0;
            end
            else if (out_take)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (out_idx_reg == 3'd7)
                    out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tdata  = out_reg[0];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == 3'd7);
    assign m_tvalid = out_valid_reg;

endmodule

### rtl/sha256_stream_hasher_core.sv
// SHA-256 stream hasher: byte-serial message intake, padding, 64-round
// compression and an eight-word digest output. Takes one data byte per
// clock while a block fills; a full block then holds the input while one
// shared round unit runs the 64 rounds and the hash words are updated.
// At end of message padding is written one byte per cycle into the block
// buffer, then the padded block is compressed and the digest handed off;
// a second padded block is needed when more than 55 bytes are already in
// the block. The digest is copied into an output register and drained H0
// first, one word per cycle while m_tready is high, as the next message
// is already being taken; a second digest waits only if the previous one
// has not been drained yet. Depends on sha256_pkg, sha256_ctrl,
// sha256_datapath.
`timescale 1ns / 1ps

module sha256_stream_hasher_core
(
    input  logic        clk,
    input  logic        rst_n,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_message
    // digest words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    sha256_pkg::dp_cmd_t    cmd;
    sha256_pkg::dp_status_t status;

    // sequencing: intake, padding, rounds, digest hand-off
    sha256_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // block buffer, round unit, hash words and output register
    sha256_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

### rtl/sha256_checker.sv
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher_core_defines.svh.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_core_defines.svh"

module sha256_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled digest word holds
    `SHA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "digest word changed while stalled")

    // digest words follow back to back in index order
    `SHA_ASSERT_NEXT(a_out_seq, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser == $past(m_tuser) + 3'd1), "digest words not contiguous")

    `SHA_ASSERT_SAME(a_last_idx, m_tvalid && m_tlast, m_tuser == 3'd7, "last flag off the eighth word")

    // m_tvalid drops in the cycle after the last digest word is taken
    `SHA_ASSERT_NEXT(a_gap, m_tvalid && m_tready && m_tlast, !m_tvalid, "digest started without a gap")

    // end of message always stops the input, for padding or a block compression
    `SHA_ASSERT_NEXT(a_pad_busy, s_tvalid && s_tready && s_tlast, !s_tready, "input taken during padding")

endmodule

bind sha256_stream_hasher_core sha256_checker u_sha256_checker (.*);

### tb/sha256_stream_hasher_core_tb.sv
// Self-checking testbench for sha256_stream_hasher_core: streams byte messages
// in, predicts each digest with its own SHA-256 routine and checks every word.
// Depends only on the RTL of the core.
`timescale 1ns / 1ps

module sha256_stream_hasher_core_tb;

    localparam int STALL_LIMIT        = 4000;  // cycles with no handshake on either side
    localparam int DIGEST_HOLD_CYCLES = 800;   // long output back-pressure stretch
    localparam int DRAIN_CYCLES       = 300;   // quiet time after the last digest word
    localparam int RANDOM_REQUESTS    = 60;
    localparam int MAX_GAP            = 18;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // SHA-256 round constants and initial hash value
    logic [31:0] round_k [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    logic [31:0] initial_hash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // predicted engine state
    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    int unsigned block_len;
    logic [63:0] length_bits;

    digest_word_t expected_words [$];

    int  error_count;
    int  requests_sent;
    int  stall_cycles;
    bit  tx_idling;
    bit  rx_idling;
    bit  hold_digests;

    sha256_stream_hasher_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------- SHA-256 predictor

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            hash_state[i] = initial_hash[i];
        block_len = 0;
        length_bits = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] sched [64];
        logic [31:0] v [8];
        logic [31:0] sig0;
        logic [31:0] sig1;
        logic [31:0] choose;
        logic [31:0] major;
        logic [31:0] t1;
        for (int i = 0; i < 16; i++)
            sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            sig0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18)
                   ^ (sched[i-15] >> 3);
            sig1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19)
                   ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + sig0 + sched[i-7] + sig1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int i = 0; i < 64; i++)
        begin
            sig1   = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1     = v[7] + sig1 + choose + round_k[i] + sched[i];
            sig0   = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + sig0 + major;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endfunction

    // Advance the predicted state by one accepted request; queue the digest on end.
    function automatic void hash_request(input logic [7:0] data, input logic has_byte,
                                         input logic end_msg);
        digest_word_t dw;
        if (has_byte)
        begin
            block_bytes[block_len] = data;
            block_len++;
            length_bits += 64'd8;
            if (block_len == 64)
            begin
                compress_block();
                block_len = 0;
            end
        end
        if (!end_msg)
            return;
        block_bytes[block_len] = 8'h80;
        block_len++;
        // no room for the length field: close this block and pad a fresh one
        if (block_len > 56)
        begin
            while (block_len < 64)
            begin
                block_bytes[block_len] = 8'h00;
                block_len++;
            end
            compress_block();
            block_len = 0;
        end
        while (block_len < 56)
        begin
            block_bytes[block_len] = 8'h00;
            block_len++;
        end
        for (int i = 0; i < 8; i++)
            block_bytes[63-i] = length_bits[8*i +: 8];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            dw.word  = hash_state[i];
            dw.index = 3'(i);
            dw.last  = (i == 7);
            expected_words.push_back(dw);
        end
        restart_message();
    endfunction

    // ---------------------------------------------------------------- stimulus side

    function automatic int pick_gap(input bit idling);
        return idling ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    // Offer one request at a falling edge and hold it until the core takes it.
    task automatic send_request(input logic [7:0] data, input logic has_byte,
                                input logic end_msg);
        int gap;
        gap = pick_gap(tx_idling);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= end_msg;
        do
            @(posedge clk);
        while (!s_tready);
        hash_request(data, has_byte, end_msg);
        requests_sent++;
    endtask

    // Stream a message of random bytes, now and then with empty requests in
    // between; close it on the last byte or on a separate byte-less request.
    task automatic send_message(input int len, input bit end_alone);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, (i == len - 1) && !end_alone);
        end
        if (end_alone || len == 0)
            send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_empty_messages();
        // empty request is dropped, then two empty messages back to back
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'hff, 1'b0, 1'b1);
        send_request(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_short_messages();
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h5a, 1'b0, 1'b0);
        send_request(8'ha5, 1'b1, 1'b0);
        send_request(8'h3c, 1'b0, 1'b1);
        send_request(8'h80, 1'b1, 1'b1);
        send_request(8'h7f, 1'b1, 1'b1);
    endtask

    task automatic test_padding_boundaries();
        // 55 bytes fit the length in one block, 56 need an extra block,
        // 64 fill a block before padding starts
        send_message(55, 1'b0);
        send_message(56, 1'b1);
        send_message(64, 1'b0);
    endtask

    task automatic test_output_backpressure();
        // stall the digest side for a long stretch while messages keep coming
        tx_idling    = 1'b0;
        hold_digests = 1'b1;
        repeat (4)
            send_message($urandom_range(1, 8), 1'b0);
        tx_idling = 1'b1;
    endtask

    task automatic test_random_messages();
        int target;
        int pick;
        int len;
        target = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < target)
        begin
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                len = $urandom_range(0, 12);
            else if (pick < 9)
                len = $urandom_range(52, 70);
            else
                len = $urandom_range(110, 130);
            // keep the total close to the planned request count
            if (len > target - requests_sent)
                len = target - requests_sent;
            send_message(len, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic finish_run();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        s_tlast       = 1'b0;
        error_count   = 0;
        requests_sent = 0;
        tx_idling     = 1'b1;
        rx_idling     = 1'b1;
        hold_digests  = 1'b0;
        for (int i = 0; i < 64; i++)
            block_bytes[i] = 8'h00;
        restart_message();
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_messages();
        test_short_messages();
        test_padding_boundaries();
        test_output_backpressure();
        test_random_messages();
        finish_run();
    end

    // ---------------------------------------------------------------- digest side

    initial
    begin : digest_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_digests)
            begin
                hold_digests = 1'b0;
                stall = DIGEST_HOLD_CYCLES;
            end
            else
                stall = pick_gap(rx_idling);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : digest_check
        digest_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected digest word %h (word_index %0d)", m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata !== want.word)
                begin
                    $error("digest_word: expected %h, got %h", want.word, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.index)
                begin
                    $error("word_index: expected %0d, got %0d", want.index, m_tuser);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_word: expected %0d, got %0d", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Abort when neither side moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

### sim.f
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_ctrl.sv
rtl/sha256_datapath.sv
rtl/sha256_stream_hasher_core.sv
rtl/sha256_checker.sv
tb/sha256_stream_hasher_core_tb.sv
